@@ hw/rtl/rms_pkg.sv @@
// shared types and constants of the running mean and deviation block
package rms_pkg;

	localparam int CHANNELS = 64;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SUM_W    = 48;
	localparam int SQ_W     = 62;
	localparam int CNT_W    = 32;
	localparam int SMP_W    = 16;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// one channel's accumulator entry
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	// report job handed from front to back
	typedef struct packed {
		logic [5:0]       ch;
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
		logic [CNT_W-1:0] cnt;
	} job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

@@ hw/rtl/running_mean_stddev.sv @@
// top level of the running mean and standard deviation block
//
//  channel | direction | handshake    | fields
//  --------+-----------+--------------+-------------------------------------
//  items   | in        | push / full  | cmd, channel, sample, report
//  results | out       | empty / pop  | out_channel, mean, std_dev, count_full
//
// in the front a sample item has a registered memory read, then the
// accumulator write; no new item is accepted until that write is done,
// which a report item holds off until the queue has room. the back runs
// 62 restoring divide steps, a square, a subtract and 16 square root steps.
// a two-entry job queue lets the front keep accumulating while the back works.
// reset empties the queue and marks every channel's accumulator as zero.
// a clear item also marks all channels zero at once.
module running_mean_stddev (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               cmd,
	input  logic [5:0]         channel,
	input  logic signed [15:0] sample,
	input  logic               report,
	output logic               empty,
	input  logic               pop,
	output logic [5:0]         out_channel,
	output logic signed [15:0] mean,
	output logic [15:0]        std_dev,
	output logic               count_full
);

	rms_pkg::job_t    f_job;
	rms_pkg::job_t    b_job;
	logic             f_push;
	logic             b_take;
	rms_pkg::q_stat_t q_stat;

	// accumulation front
	rms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.channel  (channel),
		.sample   (sample),
		.report   (report),
		.job      (f_job),
		.job_push (f_push),
		.q_stat   (q_stat)
	);

	// job queue
	rms_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wr_job (f_job),
		.rd     (b_take),
		.rd_job (b_job),
		.stat   (q_stat)
	);

	// statistics back
	rms_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (b_job),
		.q_stat      (q_stat),
		.take        (b_take),
		.empty       (empty),
		.pop         (pop),
		.out_channel (out_channel),
		.mean        (mean),
		.std_dev     (std_dev),
		.count_full  (count_full)
	);

endmodule

@@ hw/rtl/rms_front.sv @@
// front part: accepts items, updates the per-channel accumulators, issues report jobs
module rms_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 cmd,
	input  logic [5:0]           channel,
	input  logic signed [15:0]   sample,
	input  logic                 report,
	output rms_pkg::job_t        job,
	output logic                 job_push,
	input  rms_pkg::q_stat_t     q_stat
);

	rms_pkg::entry_t mem [rms_pkg::CHANNELS];
	logic [rms_pkg::CHANNELS-1:0] vld_q;

	logic                    busy_q;
	logic [rms_pkg::CH_W-1:0] addr_s1;
	logic [5:0]              ch_s1;
	logic signed [15:0]      smp_s1;
	logic                    rep_s1;
	logic                    rvld_s1;
	rms_pkg::entry_t         rd_s1;

	logic                    accept;
	logic                    smp_ok;
	logic [rms_pkg::CH_W-1:0] addr;
	rms_pkg::entry_t         cur;
	rms_pkg::entry_t         upd;
	logic signed [31:0]      sq32;
	logic                    done;

	assign full   = busy_q;
	assign accept = push & ~busy_q;
	assign addr   = rms_pkg::CH_W'(channel);
	assign smp_ok = accept & ~cmd & ({26'b0, channel} < 32'(rms_pkg::CHANNELS));

	// accumulate the sample unless the count has saturated
	always_comb begin
		cur  = rvld_s1 ? rd_s1 : '0;
		sq32 = smp_s1 * smp_s1;
		upd  = cur;
		if (cur.cnt != rms_pkg::COUNT_MAX) begin
			upd.sum = cur.sum + {{(rms_pkg::SUM_W-16){smp_s1[15]}}, smp_s1};
			upd.sq  = cur.sq + rms_pkg::SQ_W'(unsigned'(sq32));
			upd.cnt = cur.cnt + 1'b1;
		end
	end

	// finish once a report job, if any, has room in the queue
	assign done     = busy_q & (~rep_s1 | ~q_stat.full);
	assign job_push = busy_q & rep_s1 & ~q_stat.full;
	assign job      = '{ch: ch_s1, sum: upd.sum, sq: upd.sq, cnt: upd.cnt};

	// accumulator memory with registered read
	always_ff @(posedge clk) begin
		if (smp_ok) begin
			rd_s1 <= mem[addr];
		end
		if (done) begin
			mem[addr_s1] <= upd;
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (smp_ok) begin
			addr_s1 <= addr;
			ch_s1   <= channel;
			smp_s1  <= sample;
			rep_s1  <= report;
			rvld_s1 <= vld_q[addr];
		end
	end

	// control and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_q  <= '0;
		end else begin
			if (accept && cmd) begin
				vld_q <= '0;
			end
			if (smp_ok) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q         <= 1'b0;
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/rms_queue.sv @@
// short job queue between the front and back parts
module rms_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  rms_pkg::job_t    wr_job,
	input  logic             rd,
	output rms_pkg::job_t    rd_job,
	output rms_pkg::q_stat_t stat
);

	rms_pkg::job_t                slot_q [rms_pkg::QDEPTH];
	logic [rms_pkg::QPTR_W-1:0]   wp_q;
	logic [rms_pkg::QPTR_W-1:0]   rp_q;
	logic [rms_pkg::QPTR_W:0]     cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (rms_pkg::QPTR_W+1)'(rms_pkg::QDEPTH));
	assign rd_job     = slot_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/rms_back.sv @@
// back part: divides, squares and takes the square root for each report job
module rms_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rms_pkg::job_t       job,
	input  rms_pkg::q_stat_t    q_stat,
	output logic                take,
	output logic                empty,
	input  logic                pop,
	output logic [5:0]          out_channel,
	output logic signed [15:0]  mean,
	output logic [15:0]         std_dev,
	output logic                count_full
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_DIV  = 5'b00010,
		B_MUL  = 5'b00100,
		B_SUB  = 5'b01000,
		B_SQRT = 5'b10000
	} bstate_t;

	bstate_t                   st_q;
	logic [5:0]                cnt_step_q;
	logic [5:0]                ch_q;
	logic                      neg_q;
	logic                      sat_q;
	logic [rms_pkg::CNT_W-1:0] div_q;
	logic [rms_pkg::SQ_W-1:0]  n1_q;
	logic [rms_pkg::SQ_W-1:0]  n2_q;
	logic [rms_pkg::CNT_W:0]   r1_q;
	logic [rms_pkg::CNT_W:0]   r2_q;
	logic signed [15:0]        mean_q;
	logic [31:0]               msq_q;
	logic [31:0]               v_q;
	logic [31:0]               res_q;
	logic [31:0]               bit_q;
	logic                      ovld_q;

	logic [rms_pkg::CNT_W:0]   t1;
	logic [rms_pkg::CNT_W:0]   t2;
	logic                      g1;
	logic                      g2;
	logic [rms_pkg::SUM_W-1:0] mag;
	logic signed [15:0]        mean_c;
	logic [31:0]               rb;
	logic [rms_pkg::SQ_W-1:0]  msq_ext;

	assign empty       = ~ovld_q;
	assign take        = (st_q == B_IDLE) & ~q_stat.empty & ~ovld_q;
	assign mag         = job.sum[rms_pkg::SUM_W-1] ? (~job.sum + 1'b1) : job.sum;

	// one restoring step on both dividends
	assign t1 = {r1_q[rms_pkg::CNT_W-1:0], n1_q[rms_pkg::SQ_W-1]};
	assign t2 = {r2_q[rms_pkg::CNT_W-1:0], n2_q[rms_pkg::SQ_W-1]};
	assign g1 = (t1 >= {1'b0, div_q});
	assign g2 = (t2 >= {1'b0, div_q});

	assign mean_c  = neg_q ? -$signed(n1_q[15:0]) : $signed(n1_q[15:0]);
	assign rb      = res_q + bit_q;
	assign msq_ext = rms_pkg::SQ_W'(msq_q);

	// sequencer and arithmetic registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			ovld_q <= 1'b0;
		end else begin
			if (pop && ovld_q) begin
				ovld_q <= 1'b0;
			end
			unique case (st_q)
				B_IDLE: begin
					if (take) begin
						st_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (cnt_step_q == 6'(rms_pkg::SQ_W - 1)) begin
						st_q <= B_MUL;
					end
				end
				B_MUL:  st_q <= B_SUB;
				B_SUB:  st_q <= B_SQRT;
				B_SQRT: begin
					if (cnt_step_q == 6'd15) begin
						st_q   <= B_IDLE;
						ovld_q <= 1'b1;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				ch_q       <= job.ch;
				neg_q      <= job.sum[rms_pkg::SUM_W-1];
				sat_q      <= (job.cnt == rms_pkg::COUNT_MAX);
				div_q      <= job.cnt;
				n1_q       <= rms_pkg::SQ_W'(mag);
				n2_q       <= job.sq;
				r1_q       <= '0;
				r2_q       <= '0;
				cnt_step_q <= '0;
			end
			B_DIV: begin
				r1_q       <= g1 ? (t1 - {1'b0, div_q}) : t1;
				r2_q       <= g2 ? (t2 - {1'b0, div_q}) : t2;
				n1_q       <= {n1_q[rms_pkg::SQ_W-2:0], g1};
				n2_q       <= {n2_q[rms_pkg::SQ_W-2:0], g2};
				cnt_step_q <= cnt_step_q + 1'b1;
			end
			B_MUL: begin
				mean_q <= mean_c;
				// square at full 32-bit width
				msq_q  <= unsigned'(32'(mean_c) * 32'(mean_c));
			end
			B_SUB: begin
				v_q        <= (n2_q > msq_ext) ? 32'(n2_q - msq_ext) : '0;
				res_q      <= '0;
				bit_q      <= 32'h4000_0000;
				cnt_step_q <= '0;
			end
			B_SQRT: begin
				if (v_q >= rb) begin
					v_q   <= v_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q      <= bit_q >> 2;
				cnt_step_q <= cnt_step_q + 1'b1;
			end
			default: begin
				cnt_step_q <= '0;
			end
		endcase
	end

	// result register, held until transferred
	always_ff @(posedge clk) begin
		if (st_q == B_SQRT && cnt_step_q == 6'd15) begin
			out_channel <= ch_q;
			mean        <= mean_q;
			std_dev     <= (v_q >= rb) ? 16'((res_q >> 1) + bit_q) : 16'(res_q >> 1);
			count_full  <= sat_q;
		end
	end

endmodule

@@ hw/rtl/rms_checker.sv @@
// port checker for the running mean and standard deviation block
module rms_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               cmd,
	input logic               empty,
	input logic               pop,
	input logic [5:0]         out_channel,
	input logic signed [15:0] mean,
	input logic [15:0]        std_dev,
	input logic               count_full
);

	// a sample transfer occupies the front for the next cycle
	a_smp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && !cmd |=> full)
		else $error("front not busy after sample transfer");

	// a clear leaves the front free
	a_clr_free: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && cmd |=> !full)
		else $error("front busy after clear transfer");

	// a waiting result holds until transferred
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_channel) && $stable(mean)
			&& $stable(std_dev) && $stable(count_full))
		else $error("waiting result changed");

	// deviation of Q1.15 samples stays within the square root of 2^31
	a_sd_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> std_dev <= 16'd46341)
		else $error("deviation out of range");

endmodule

bind running_mean_stddev rms_checker u_rms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.cmd         (cmd),
	.empty       (empty),
	.pop         (pop),
	.out_channel (out_channel),
	.mean        (mean),
	.std_dev     (std_dev),
	.count_full  (count_full)
);
